### sv/sawbc_pkg.sv
// Shared types, constants and helper functions for the set-associative write-back cache.
package sawbc_pkg;

  localparam int MAX_LINES      = 64;
  localparam int LINE_IW        = 6;
  localparam int MAX_LINE_WORDS = 32;
  localparam int WORD_IW        = 5;
  localparam int MEM_BYTES      = 8192;
  localparam int MEM_WORDS      = MEM_BYTES / 4;
  localparam int MEM_AW         = 11;
  localparam int LMEM_WORDS     = MAX_LINES * MAX_LINE_WORDS;
  localparam int LMEM_AW        = LINE_IW + WORD_IW;
  localparam int ADDR_W         = 13;
  localparam int TAG_W          = 13;
  localparam int CNT_W          = 28;
  localparam int CFG_IW         = 3;
  localparam int CFG_DW         = 10;
  localparam int BOOT_WORDS     = 20;

  localparam logic [CNT_W-1:0] CYCLE_LIMIT = 28'd268435454;
  localparam logic [CNT_W-1:0] STAMP_INIT  = 28'hfffffff;

  typedef enum logic [CFG_IW-1:0] {
    CFG_WPL   = 3'd0,
    CFG_LINES = 3'd1,
    CFG_WAYS  = 3'd2,
    CFG_HIT   = 3'd3,
    CFG_MISS  = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DECIDE,
    ST_WB,
    ST_FILL,
    ST_ACCESS,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic prep;
    logic scan;
    logic decide;
    logic wb;
    logic fill;
    logic access;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic hit;
    logic vic_dirty;
    logic xfer_done;
    logic out_full;
  } sts_t;

  function automatic logic [2:0] flog2(input logic [6:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 1; k < 7; k++) begin
      if (v[k]) r = 3'(k);
    end
    return r;
  endfunction

  function automatic logic [31:0] boot_word(input logic [4:0] i);
    logic [31:0] w;
    case (i)
      5'd0:    w = 32'hdeadbeef;
      5'd1:    w = 32'hbadacafe;
      5'd2:    w = 32'h01234567;
      5'd3:    w = 32'h89abcdef;
      5'd4:    w = 32'h00112233;
      5'd5:    w = 32'h44556677;
      5'd6:    w = 32'h8899aabb;
      5'd7:    w = 32'hccddeeff;
      5'd8:    w = 32'h68656c6c;
      5'd9:    w = 32'h6f20776f;
      5'd10:   w = 32'h726c6421;
      5'd11:   w = 32'h89abcdef;
      5'd12:   w = 32'h50525456;
      5'd13:   w = 32'h585a5c5e;
      5'd14:   w = 32'h60626466;
      5'd15:   w = 32'h686a6c6e;
      5'd16:   w = 32'h70727476;
      5'd17:   w = 32'h787a7c7e;
      5'd18:   w = 32'h80828486;
      5'd19:   w = 32'h888a8c8e;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

### sv/sawbc_ctrl.sv
// Sequencing state machine: clearing pass, tag scan, write-back, fill and access.
module sawbc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sawbc_pkg::sts_t sts,
  output sawbc_pkg::cmd_t cmd
);

  sawbc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sawbc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      sawbc_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_nxt = sawbc_pkg::ST_IDLE;
      end
      sawbc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sawbc_pkg::ST_PREP;
        end
      end
      sawbc_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sawbc_pkg::ST_SCAN;
      end
      sawbc_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = sawbc_pkg::ST_DECIDE;
      end
      sawbc_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.hit)            state_nxt = sawbc_pkg::ST_ACCESS;
        else if (sts.vic_dirty) state_nxt = sawbc_pkg::ST_WB;
        else                    state_nxt = sawbc_pkg::ST_FILL;
      end
      sawbc_pkg::ST_WB: begin
        cmd.wb = 1'b1;
        if (sts.xfer_done) state_nxt = sawbc_pkg::ST_FILL;
      end
      sawbc_pkg::ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.xfer_done) state_nxt = sawbc_pkg::ST_ACCESS;
      end
      sawbc_pkg::ST_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = sawbc_pkg::ST_RESP;
      end
      sawbc_pkg::ST_RESP: begin
        if (!sts.out_full) begin
          cmd.resp  = 1'b1;
          state_nxt = sawbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sawbc_pkg::ST_CLEAR;
    endcase
  end

endmodule

### sv/sawbc_dp.sv
// Datapath: configuration, geometry, tag and stamp stores, line and backing memories.
module sawbc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sawbc_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [sawbc_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                           in_opcode,
  input  logic [sawbc_pkg::ADDR_W-1:0]   in_byte_address,
  input  logic [31:0]                    in_store_word_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_was_hit,
  output logic [31:0]                    out_loaded_word,
  output logic [sawbc_pkg::CNT_W-1:0]    out_running_cycles,
  input  sawbc_pkg::cmd_t                cmd,
  output sawbc_pkg::sts_t                sts
);

  localparam int LW = sawbc_pkg::LINE_IW;
  localparam int WW = sawbc_pkg::WORD_IW;
  localparam int CW = sawbc_pkg::CNT_W;
  localparam int MA = sawbc_pkg::MEM_AW;

  // configuration registers
  logic [5:0] wpl_r;
  logic [6:0] lines_r, ways_cfg_r;
  logic [7:0] hit_cost_r;
  logic [9:0] miss_cost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpl_r       <= 6'd4;
      lines_r     <= 7'd16;
      ways_cfg_r  <= 7'd2;
      hit_cost_r  <= 8'd1;
      miss_cost_r <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        sawbc_pkg::CFG_WPL:   wpl_r       <= cfg_wdata[5:0];
        sawbc_pkg::CFG_LINES: lines_r     <= cfg_wdata[6:0];
        sawbc_pkg::CFG_WAYS:  ways_cfg_r  <= cfg_wdata[6:0];
        sawbc_pkg::CFG_HIT:   hit_cost_r  <= cfg_wdata[7:0];
        sawbc_pkg::CFG_MISS:  miss_cost_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // geometry, re-derived every cycle from the registers
  logic [5:0] wpl_c;
  logic [6:0] lines_c, ways_c;
  logic [2:0] lgw_c, idx_c;
  logic [2:0] lgw_r, idx_r;
  logic [6:0] ways_r;

  always_comb begin
    wpl_c = wpl_r;
    if (wpl_c == 6'd0) wpl_c = 6'd1;
    if (wpl_c > 6'd32) wpl_c = 6'd32;
    lines_c = lines_r;
    if (lines_c == 7'd0) lines_c = 7'd1;
    if (lines_c > 7'd64) lines_c = 7'd64;
    ways_c = ways_cfg_r;
    if (ways_c == 7'd0) ways_c = 7'd1;
    if (ways_c > lines_c) ways_c = lines_c;
    lgw_c = sawbc_pkg::flog2({1'b0, wpl_c});
    idx_c = 3'd0;
    for (int k = 0; k < 7; k++) begin
      if (({7'd0, ways_c} << k) <= {7'd0, lines_c}) idx_c = 3'(k);
    end
  end

  always_ff @(posedge clk) begin
    lgw_r  <= lgw_c;
    idx_r  <= idx_c;
    ways_r <= ways_c;
  end

  // item capture
  logic                          op_r;
  logic [sawbc_pkg::ADDR_W-1:0]  addr_r;
  logic [31:0]                   val_r;
  logic [MA-1:0]                 wa;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_opcode;
      addr_r <= {in_byte_address[sawbc_pkg::ADDR_W-1:2], 2'b00};
      val_r  <= in_store_word_value;
    end
  end

  assign wa = addr_r[sawbc_pkg::ADDR_W-1:2];

  // address split
  logic [MA-1:0]               sh_set, sh_tag;
  logic [LW-1:0]               set_c, set_r, base_r;
  logic [WW-1:0]               wmask, woff_r;
  logic [sawbc_pkg::TAG_W-1:0] tag_r;
  logic [LW+6:0]               base_c;

  always_comb begin
    sh_set = wa >> lgw_r;
    sh_tag = wa >> ({1'b0, lgw_r} + {1'b0, idx_r});
    set_c  = sh_set[LW-1:0] & ((LW'(1) << idx_r) - LW'(1));
    wmask  = (WW'(1) << lgw_r) - WW'(1);
    base_c = (LW+7)'(set_c) * (LW+7)'(ways_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      set_r  <= set_c;
      tag_r  <= {2'b00, sh_tag};
      woff_r <= wa[WW-1:0] & wmask;
      base_r <= base_c[LW-1:0];
    end
  end

  // line state
  logic [sawbc_pkg::MAX_LINES-1:0] valid_r, dirty_r;
  logic [sawbc_pkg::TAG_W-1:0]     tag_mem [sawbc_pkg::MAX_LINES];
  logic [CW-1:0]                   stamp_mem [sawbc_pkg::MAX_LINES];

  // way scan, one way issued per cycle, compared the cycle after
  logic [6:0]                  w_r;
  logic                        pv_q, vld_q;
  logic [LW-1:0]               n_q, n_c;
  logic [sawbc_pkg::TAG_W-1:0] tag_q, vtag_r;
  logic [CW-1:0]               stamp_q, min_r;
  logic                        hit_f_r, inv_f_r;
  logic [LW-1:0]               hline_r, vline_r, line_r;
  logic                        scan_issue;

  assign n_c        = base_r + w_r[LW-1:0];
  assign scan_issue = cmd.scan && (w_r < ways_r);

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      tag_q   <= tag_mem[n_c];
      stamp_q <= stamp_mem[n_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      w_r     <= 7'd0;
      pv_q    <= 1'b0;
      hit_f_r <= 1'b0;
      inv_f_r <= 1'b0;
      min_r   <= sawbc_pkg::STAMP_INIT;
      hline_r <= '0;
      vline_r <= '0;
      vtag_r  <= '0;
    end else if (cmd.scan) begin
      pv_q <= scan_issue;
      if (scan_issue) begin
        w_r   <= w_r + 7'd1;
        n_q   <= n_c;
        vld_q <= valid_r[n_c];
      end
      if (pv_q) begin
        if (!hit_f_r && vld_q && tag_q == tag_r) begin
          hit_f_r <= 1'b1;
          hline_r <= n_q;
        end
        if (!inv_f_r) begin
          if (!vld_q) begin
            inv_f_r <= 1'b1;
            vline_r <= n_q;
            vtag_r  <= tag_q;
          end else if (stamp_q < min_r) begin
            min_r   <= stamp_q;
            vline_r <= n_q;
            vtag_r  <= tag_q;
          end
        end
      end
    end
  end

  // line transfer addresses
  logic [MA-1:0]   wb_base_r, fill_base_r;
  logic [23:0]     tag_sh;
  logic [WW:0]     j_r, wpl_n;
  logic [WW-1:0]   jq;
  logic            p_q, xfer, xfer_issue, xfer_done;

  assign tag_sh     = {11'd0, vtag_r} << ({1'b0, lgw_r} + {1'b0, idx_r});
  assign wpl_n      = (WW+1)'(1) << lgw_r;
  assign xfer       = cmd.wb || cmd.fill;
  assign xfer_issue = xfer && (j_r < wpl_n);
  assign xfer_done  = (j_r == wpl_n) && !p_q;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      line_r      <= hit_f_r ? hline_r : vline_r;
      wb_base_r   <= tag_sh[MA-1:0] | (MA'(set_r) << lgw_r);
      fill_base_r <= wa & ~{{(MA-WW){1'b0}}, wmask};
      j_r         <= '0;
      p_q         <= 1'b0;
    end else if (xfer) begin
      p_q <= xfer_issue;
      if (xfer_issue) begin
        j_r <= j_r + (WW+1)'(1);
        jq  <= j_r[WW-1:0];
      end
      if (xfer_done) j_r <= '0;
    end
  end

  // clearing pass address, shared by both memories
  logic [MA-1:0] clr_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_a_r <= '0;
    end else if (cmd.clear) begin
      clr_a_r <= clr_a_r + MA'(1);
    end
  end

  // line data memory, zeroed by the clearing pass after reset
  logic [31:0]                     lmem [sawbc_pkg::LMEM_WORDS];
  logic [31:0]                     lm_q, bm_q;
  logic                            lm_re, lm_we;
  logic [sawbc_pkg::LMEM_AW-1:0]   lm_ra, lm_wa;
  logic [31:0]                     lm_wd;

  always_comb begin
    lm_re = (cmd.wb && xfer_issue) || (cmd.access && !op_r);
    lm_ra = cmd.access ? {line_r, woff_r} : {line_r, j_r[WW-1:0]};
    lm_we = cmd.clear || (cmd.fill && p_q) || (cmd.access && op_r);
    if (cmd.clear) begin
      lm_wa = clr_a_r;
      lm_wd = 32'd0;
    end else begin
      lm_wa = cmd.access ? {line_r, woff_r} : {line_r, jq};
      lm_wd = cmd.access ? val_r : bm_q;
    end
  end

  always_ff @(posedge clk) begin
    if (lm_we) lmem[lm_wa] <= lm_wd;
    if (lm_re) lm_q <= lmem[lm_ra];
  end

  // backing memory, loaded by the clearing pass after reset
  logic [31:0]   bmem [sawbc_pkg::MEM_WORDS];
  logic [MA-1:0] bm_ra, bm_wa;
  logic          bm_re, bm_we;
  logic [31:0]   bm_wd;

  always_comb begin
    bm_re = cmd.fill && xfer_issue;
    bm_ra = fill_base_r | MA'(j_r[WW-1:0]);
    bm_we = cmd.clear || (cmd.wb && p_q);
    bm_wa = cmd.clear ? clr_a_r : (wb_base_r | MA'(jq));
    if (cmd.clear) begin
      bm_wd = (clr_a_r < MA'(sawbc_pkg::BOOT_WORDS)) ? sawbc_pkg::boot_word(clr_a_r[4:0])
                                                     : 32'd0;
    end else begin
      bm_wd = lm_q;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) bmem[bm_wa] <= bm_wd;
    if (bm_re) bm_q <= bmem[bm_ra];
  end

  // access: stamp, tag, flags and running count
  logic [CW-1:0] cnt_r;
  logic [CW:0]   sum_c;

  assign sum_c = {1'b0, cnt_r} +
                 (hit_f_r ? (CW+1)'(hit_cost_r) : (CW+1)'(miss_cost_r));

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      stamp_mem[line_r] <= cnt_r;
      if (!hit_f_r) tag_mem[line_r] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.access) begin
      valid_r[line_r] <= 1'b1;
      dirty_r[line_r] <= op_r || (hit_f_r && dirty_r[line_r]);
      cnt_r <= (sum_c > (CW+1)'(sawbc_pkg::CYCLE_LIMIT)) ? sawbc_pkg::CYCLE_LIMIT
                                                          : sum_c[CW-1:0];
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_was_hit        <= hit_f_r;
      out_loaded_word    <= op_r ? 32'd0 : lm_q;
      out_running_cycles <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.clear_done = &clr_a_r;
    sts.scan_done  = (w_r >= ways_r) && !pv_q;
    sts.hit        = hit_f_r;
    sts.vic_dirty  = dirty_r[vline_r];
    sts.xfer_done  = xfer_done;
    sts.out_full   = out_valid_r && !out_ready;
  end

endmodule

### sv/set_assoc_writeback_cache.sv
// Top level of the set-associative write-back write-allocate cache with LRU stamps.
//
//   channel  direction  handshake            payload
//   in_      inbound    in_valid / in_ready  opcode, byte address, store word
//   out_     outbound   out_valid/out_ready  hit flag, loaded word, running cycles
//   cfg_     inbound    cfg_we (no wait)     register index, write data
//
// One item at a time. The tag and stamp stores are read one way per cycle, then the last
// way is compared and the scan drains before the hit or miss is decided. A miss adds the
// fill and, for a dirty victim, the write-back before it, one word per memory port cycle
// (words_per_line after clamping and rounding down to a power of two).
// After reset a clearing pass loads the backing memory and zeroes the line memory; no item
// is taken during it. A waiting result does not stop the next item being accepted; only
// that item's own result step holds until the output register is free.
module set_assoc_writeback_cache (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sawbc_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sawbc_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [sawbc_pkg::ADDR_W-1:0]  in_byte_address,
  input  logic [31:0]                   in_store_word_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_was_hit,
  output logic [31:0]                   out_loaded_word,
  output logic [sawbc_pkg::CNT_W-1:0]   out_running_cycles
);

  sawbc_pkg::cmd_t cmd;
  sawbc_pkg::sts_t sts;

  // sequencer: owns the input handshake and steps the datapath
  sawbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: holds config, line state, both memories and the result register
  sawbc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_opcode           (in_opcode),
    .in_byte_address     (in_byte_address),
    .in_store_word_value (in_store_word_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_was_hit         (out_was_hit),
    .out_loaded_word     (out_loaded_word),
    .out_running_cycles  (out_running_cycles),
    .cmd                 (cmd),
    .sts                 (sts)
  );

`ifndef SYNTHESIS
  // an accepted item drops in_ready, blocking the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // the running count never passes its ceiling
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_running_cycles <= sawbc_pkg::CYCLE_LIMIT)
    else $error("running count above ceiling");

  // sequencer commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("overlapping datapath commands");
`endif

endmodule
